/* design/smd_pkg.sv */
// Shared types and constants for the source map entry decoder.
// Depends on nothing; every design module imports it, the interfaces do not.
`default_nettype none

package smd_pkg;

    // Numeric field width; the accumulator holds the saturation limit.
    localparam int FIELD_BITS = 32;
    localparam int ACC_W      = (FIELD_BITS - 1 < 31) ? FIELD_BITS - 1 : 31;
    localparam int PROD_W     = ACC_W + 4;
    localparam logic [ACC_W-1:0] NUM_MAX = {ACC_W{1'b1}};

    localparam logic [15:0] MOD_MAX = 16'hFFFF;

    // Characters of the map text.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_INTO  = 8'h69;
    localparam logic [7:0] CHAR_OUT   = 8'h6F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Jump codes.
    localparam logic [1:0] JUMP_UNSET   = 2'd0;
    localparam logic [1:0] JUMP_INTO    = 2'd1;
    localparam logic [1:0] JUMP_OUT     = 2'd2;
    localparam logic [1:0] JUMP_REGULAR = 2'd3;

    // Field positions within an entry.
    localparam logic [2:0] FIELD_START    = 3'd0;
    localparam logic [2:0] FIELD_LENGTH   = 3'd1;
    localparam logic [2:0] FIELD_FILE     = 3'd2;
    localparam logic [2:0] FIELD_JUMP     = 3'd3;
    localparam logic [2:0] FIELD_MODIFIER = 3'd4;
    localparam logic [2:0] FIELD_PAST     = 3'd5;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] file;
        logic [1:0]  jump;
        logic [15:0] modifier;
        logic [4:0]  set_mask;
    } entry_t;

    // Handshake between the input register and the parse stage.
    typedef struct packed {
        logic valid;
        item_t item;
    } stage_t;

endpackage

`default_nettype wire

/* design/smd_if.sv */
// Channel interfaces of the source map entry decoder: input item,
// result item and target_entry configuration write. No dependencies.
`default_nettype none

interface smd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface smd_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] src_start;
    logic signed [31:0] src_length;
    logic signed [31:0] file_index;
    logic [1:0]         jump_kind;
    logic [15:0]        modifier_depth;
    logic [4:0]         set_mask;

    modport source (output valid, found, src_start, src_length, file_index, jump_kind,
                    modifier_depth, set_mask, input ready);
    modport sink (input valid, found, src_start, src_length, file_index, jump_kind,
                  modifier_depth, set_mask, output ready);
endinterface

interface smd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_entry;

    modport source (output valid, target_entry, input ready);
    modport sink (input valid, target_entry, output ready);
endinterface

`default_nettype wire

/* design/smd_in_stage.sv */
// Input register of the decoder: captures one item per transfer.
// Depends on smd_pkg and smd_in_if.
`default_nettype none

module smd_in_stage
    import smd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    smd_in_if.sink    item,
    input  wire logic advance,
    output stage_t    stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Refill whenever the register is empty or the parse stage drains it this cycle.
    assign item.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item.ready)
        begin
            valid_next = item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.text_byte   <= item.text_byte;
            item_reg.end_of_text <= item.end_of_text;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

/* design/smd_parser.sv */
// Parse stage: per-byte field decode, entry tracking and result register.
// Depends on smd_pkg, smd_out_if and smd_cfg_if.
`default_nettype none

module smd_parser
    import smd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire stage_t stage,
    output logic        advance,
    smd_cfg_if.sink     cfg,
    smd_out_if.source   result
);

    logic [31:0]      target_reg;
    logic [31:0]      count_reg, count_next;
    logic [2:0]       pos_reg, pos_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             minus_reg, minus_next;
    logic             nonempty_reg, nonempty_next;
    entry_t           work_reg, work_next;
    entry_t           held_reg, held_next;
    logic             reported_reg, reported_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    entry_t           out_entry_reg, out_entry_next;

    logic              fire;
    logic [7:0]        ch;
    logic              is_digit;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_sat;
    logic [31:0]       acc_val;
    logic              neg;
    entry_t            work_fe;

    assign cfg.ready = 1'b1;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = advance && stage.valid;
    assign ch      = stage.item.text_byte;
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

    // acc * 10 + digit, saturating
    assign prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1)
                + PROD_W'(ch[3:0]);
    assign acc_sat = (prod > PROD_W'(NUM_MAX)) ? NUM_MAX : prod[ACC_W-1:0];

    assign acc_val = 32'(acc_reg);
    assign neg     = minus_reg && (acc_val != 32'd0);

    // Working values after the current field closes.
    always_comb
    begin
        work_fe = work_reg;
        if (nonempty_reg && (pos_reg < FIELD_PAST))
        begin
            unique case (pos_reg)
                FIELD_START:  work_fe.start  = neg ? 32'hFFFF_FFFF : acc_val;
                FIELD_LENGTH: work_fe.length = neg ? 32'hFFFF_FFFF : acc_val;
                FIELD_FILE:   work_fe.file   = neg ? 32'hFFFF_FFFF : acc_val;
                FIELD_JUMP:   work_fe.jump   = acc_reg[1:0];
                default:
                begin
                    if (neg)
                        work_fe.modifier = 16'd0;
                    else if (acc_val > 32'(MOD_MAX))
                        work_fe.modifier = MOD_MAX;
                    else
                        work_fe.modifier = acc_val[15:0];
                end
            endcase
            work_fe.set_mask = work_reg.set_mask | (5'd1 << pos_reg);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        minus_next     = minus_reg;
        nonempty_next  = nonempty_reg;
        work_next      = work_reg;
        held_next      = held_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_entry_next = out_entry_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            if (stage.item.end_of_text)
            begin
                if (!reported_reg)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_entry_next = held_reg;
                end
                count_next    = '0;
                pos_next      = FIELD_START;
                acc_next      = '0;
                minus_next    = 1'b0;
                nonempty_next = 1'b0;
                work_next     = '0;
                held_next     = '0;
                reported_next = 1'b0;
            end
            else if (!reported_reg)
            begin
                if (ch == CHAR_COLON)
                begin
                    work_next     = work_fe;
                    acc_next      = '0;
                    minus_next    = 1'b0;
                    nonempty_next = 1'b0;
                    if (pos_reg < FIELD_PAST)
                        pos_next = pos_reg + 3'd1;
                end
                else if (ch == CHAR_SEMI)
                begin
                    work_next     = work_fe;
                    held_next     = work_fe;
                    acc_next      = '0;
                    minus_next    = 1'b0;
                    nonempty_next = 1'b0;
                    pos_next      = FIELD_START;
                    if (count_reg == target_reg)
                    begin
                        reported_next  = 1'b1;
                        out_valid_next = 1'b1;
                        out_found_next = 1'b1;
                        out_entry_next = work_fe;
                    end
                    else
                    begin
                        count_next = count_reg + 32'd1;
                    end
                end
                else
                begin
                    nonempty_next = 1'b1;
                    if (pos_reg == FIELD_JUMP)
                    begin
                        if (ch == CHAR_INTO)
                            acc_next = ACC_W'(JUMP_INTO);
                        else if (ch == CHAR_OUT)
                            acc_next = ACC_W'(JUMP_OUT);
                        else if (ch == CHAR_MINUS)
                            acc_next = ACC_W'(JUMP_REGULAR);
                    end
                    else if (ch == CHAR_MINUS)
                    begin
                        minus_next = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        acc_next = acc_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            count_reg     <= '0;
            pos_reg       <= FIELD_START;
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
            nonempty_reg  <= 1'b0;
            work_reg      <= '0;
            held_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                target_reg <= cfg.target_entry;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            minus_reg     <= minus_next;
            nonempty_reg  <= nonempty_next;
            work_reg      <= work_next;
            held_reg      <= held_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_entry_reg <= out_entry_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = out_found_reg;
    assign result.src_start      = out_entry_reg.start;
    assign result.src_length     = out_entry_reg.length;
    assign result.file_index     = out_entry_reg.file;
    assign result.jump_kind      = out_entry_reg.jump;
    assign result.modifier_depth = out_entry_reg.modifier;
    assign result.set_mask       = out_entry_reg.set_mask;

    // Field position never runs past the overflow slot.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FIELD_PAST)
        else $error("field position out of range");

    // A found result is only pending while the stream is marked reported.
    a_found_reported: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |-> reported_reg)
        else $error("found result without reported flag");

    // End of stream returns parse state to reset.
    a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage.item.end_of_text |=> (count_reg == 32'd0) && !reported_reg
            && (pos_reg == FIELD_START) && !nonempty_reg)
        else $error("parse state not cleared at end of stream");

    // Closing an entry restarts at the first field with an empty accumulator.
    a_semi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !stage.item.end_of_text && !reported_reg && (ch == CHAR_SEMI)
            |=> (pos_reg == FIELD_START) && (acc_reg == '0) && !minus_reg)
        else $error("entry close did not restart field decode");

endmodule

`default_nettype wire

/* design/source_map_entry_decoder_top.sv */
// A transferred byte is held in the input register, then decoded by the parse stage,
// which registers its result, if any, in the result register.
// Throughput: one byte per cycle, set by the single parse stage. While a result waits
// for its transfer the parse stage holds, and the input register takes a byte only while empty.
// Reset (rst_n, async low): target_entry 0, empty stream, no result pending.
// Top level of the source map entry decoder; depends on smd_pkg, smd_if, stages.
`default_nettype none

module source_map_entry_decoder_top
    import smd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    smd_in_if.sink    item,
    smd_cfg_if.sink   cfg,
    smd_out_if.source result
);

    stage_t stage;
    logic   advance;

    smd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    smd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

`default_nettype wire

/* verif/smd_map_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the source map entry decoder test: predicts the decoded entry
// from each accepted text byte and checks every result transfer. Uses smd_pkg.
package smd_map_scoreboard_pkg;
    import smd_pkg::*;

    typedef struct packed {
        logic   found;
        entry_t fields;
    } map_result_t;

    // Decimal fields saturate at the largest positive field value, never above 31 bits.
    localparam longint unsigned NUMBER_LIMIT = (FIELD_BITS - 1 < 31)
        ? ((64'd1 << (FIELD_BITS - 1)) - 64'd1) : 64'h7FFF_FFFF;

    class map_scoreboard;
        bit [31:0]   target;
        bit [31:0]   entry_index;
        logic [2:0]  field_slot;
        bit [63:0]   number_acc;
        bit          negative;
        bit          field_has_text;
        bit          done;
        entry_t      pending_entry;
        entry_t      committed;
        map_result_t expected_q[$];
        int          errors;
        int          results_checked;

        function new();
            target = '0;
            errors = 0;
            results_checked = 0;
            restart();
        endfunction

        function void restart();
            entry_index = '0;
            field_slot = FIELD_START;
            number_acc = '0;
            negative = 1'b0;
            field_has_text = 1'b0;
            done = 1'b0;
            pending_entry = '0;
            committed = '0;
        endfunction

        function void set_target(bit [31:0] value);
            target = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void queue_result(bit found_it);
            map_result_t r;
            r.found = found_it;
            r.fields = committed;
            expected_q.push_back(r);
        endfunction

        function void close_field();
            bit [31:0] magnitude;
            bit        to_minus;
            if (field_has_text && field_slot < FIELD_PAST)
            begin
                magnitude = number_acc[31:0];
                to_minus = negative && magnitude != 0;
                case (field_slot)
                    FIELD_START:  pending_entry.start = to_minus ? 32'hFFFF_FFFF : magnitude;
                    FIELD_LENGTH: pending_entry.length = to_minus ? 32'hFFFF_FFFF : magnitude;
                    FIELD_FILE:   pending_entry.file = to_minus ? 32'hFFFF_FFFF : magnitude;
                    FIELD_JUMP:   pending_entry.jump = number_acc[1:0];
                    default:
                    begin
                        if (to_minus)
                            pending_entry.modifier = '0;
                        else if (magnitude > MOD_MAX)
                            pending_entry.modifier = MOD_MAX;
                        else
                            pending_entry.modifier = magnitude[15:0];
                    end
                endcase
                pending_entry.set_mask[field_slot] = 1'b1;
            end
            number_acc = '0;
            negative = 1'b0;
            field_has_text = 1'b0;
        endfunction

        function void note_item(bit [7:0] c, bit eot);
            bit [63:0] next;
            if (eot)
            begin
                if (!done)
                    queue_result(1'b0);
                restart();
                return;
            end
            if (done)
                return;
            if (c == CHAR_COLON)
            begin
                close_field();
                if (field_slot < FIELD_PAST)
                    field_slot++;
            end
            else if (c == CHAR_SEMI)
            begin
                close_field();
                field_slot = FIELD_START;
                committed = pending_entry;
                if (entry_index == target)
                begin
                    done = 1'b1;
                    queue_result(1'b1);
                end
                else
                    entry_index++;
            end
            else
            begin
                field_has_text = 1'b1;
                if (field_slot == FIELD_JUMP)
                begin
                    // last jump mark wins, anything else leaves the code alone
                    if (c == CHAR_INTO)
                        number_acc = JUMP_INTO;
                    else if (c == CHAR_OUT)
                        number_acc = JUMP_OUT;
                    else if (c == CHAR_MINUS)
                        number_acc = JUMP_REGULAR;
                end
                else if (c == CHAR_MINUS)
                    negative = 1'b1;
                else if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    next = number_acc * 10 + (c - CHAR_ZERO);
                    number_acc = (next > NUMBER_LIMIT) ? NUMBER_LIMIT : next;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(map_result_t got);
            map_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer: found %0b start %0h mask %0h",
                         $time, got.found, got.fields.start, got.fields.set_mask);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            compare_field("found", want.found, got.found);
            compare_field("src_start", want.fields.start, got.fields.start);
            compare_field("src_length", want.fields.length, got.fields.length);
            compare_field("file_index", want.fields.file, got.fields.file);
            compare_field("jump_kind", want.fields.jump, got.fields.jump);
            compare_field("modifier_depth", want.fields.modifier, got.fields.modifier);
            compare_field("set_mask", want.fields.set_mask, got.fields.set_mask);
        endfunction
    endclass

endpackage

/* verif/source_map_entry_decoder_top_test.sv */
`timescale 1ns / 1ps
// Test of source_map_entry_decoder_top: streams of map text with random idling
// on both channels, results checked against a scoreboard prediction.
// Depends on smd_pkg, smd_if and smd_map_scoreboard_pkg.
module source_map_entry_decoder_top_test;
    import smd_pkg::*;
    import smd_map_scoreboard_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TOTAL_ITEMS    = 1000;
    localparam int CYCLE_LIMIT    = 500000;

    typedef bit [7:0] text_q_t[$];

    logic clk = 1'b0;
    logic rst_n;

    smd_in_if  in_ch();
    smd_out_if out_ch();
    smd_cfg_if cfg_ch();

    map_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          item_count = 0;
    bit          holdoff_go = 1'b0;
    bit          no_idle = 1'b0;

    source_map_entry_decoder_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .cfg    (cfg_ch),
        .result (out_ch)
    );

    always #5 clk = ~clk;

    // Mostly short stalls, now and then a long one.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void put_text(ref text_q_t q, input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            q.push_back(s[k]);
    endfunction

    function automatic void put_fields(ref text_q_t q, input int count);
        int       slot;
        int       r;
        int       len;
        bit [7:0] c;
        string    jump_marks;
        jump_marks = "io-x7";
        for (slot = 0; slot < count; slot++)
        begin
            if (slot > 0)
                q.push_back(CHAR_COLON);
            r = $urandom_range(0, 99);
            if (slot == FIELD_JUMP)
            begin
                if (r >= 75)
                begin
                    repeat ($urandom_range(1, 4))
                        q.push_back(jump_marks[$urandom_range(0, 4)]);
                end
                else if (r >= 25)
                    q.push_back(jump_marks[$urandom_range(0, 2)]);
            end
            else if (r < 25)
                ; // empty field keeps the previous value
            else if (r < 55)
                put_text(q, $sformatf("%0d", $urandom_range(0, 999)));
            else if (r < 65)
                put_text(q, $sformatf("-%0d", $urandom_range(0, 99)));
            else if (r < 75)
            begin
                len = $urandom_range(6, 12);
                repeat (len)
                    q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            else if (r < 82)
            begin
                case ($urandom_range(0, 3))
                    0: put_text(q, "2147483647");
                    1: put_text(q, "2147483648");
                    2: put_text(q, "65535");
                    default: put_text(q, "65536");
                endcase
            end
            else if (r < 88)
                put_text(q, ($urandom_range(0, 1) != 0) ? "-0" : "-");
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_SEMI || c == CHAR_COLON)
                        c = CHAR_NINE;
                    q.push_back(c);
                end
            end
            // stray byte, may break the entry structure
            if ($urandom_range(0, 99) < 3)
                q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_item(input bit [7:0] b, input bit eot);
        int gap;
        gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : stall_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.text_byte <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        item_count++;
        sb.note_item(b, eot);
    endtask

    task automatic send_stream(input text_q_t q);
        foreach (q[i])
            send_item(q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a stream may still be in the parse stage without a result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input bit [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.target_entry <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_target(value);
    endtask

    initial
    begin : result_sink
        map_result_t got;
        int          run_left;
        bit          ready_now;
        run_left = 0;
        ready_now = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.found = out_ch.found;
                got.fields.start = out_ch.src_start;
                got.fields.length = out_ch.src_length;
                got.fields.file = out_ch.file_index;
                got.fields.jump = out_ch.jump_kind;
                got.fields.modifier = out_ch.modifier_depth;
                got.fields.set_mask = out_ch.set_mask;
                sb.check_result(got);
            end
            if (holdoff_go)
            begin
                holdoff_go = 1'b0;
                ready_now = 1'b0;
                run_left = HOLDOFF_CYCLES;
            end
            else if (run_left > 0)
                run_left--;
            else if (no_idle)
                ready_now = 1'b1;
            else if ($urandom_range(0, 1) != 0)
            begin
                ready_now = 1'b1;
                run_left = $urandom_range(1, 20);
            end
            else
            begin
                ready_now = 1'b0;
                run_left = stall_len();
            end
            out_ch.ready <= ready_now;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        text_q_t   text;
        bit [31:0] target_now;
        int        entries;
        in_ch.valid <= 1'b0;
        in_ch.text_byte <= '0;
        in_ch.end_of_text <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.target_entry <= '0;
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Negative start, minus with zero magnitude, jump out, bytes after the report.
        write_target(32'd0);
        text.delete();
        put_text(text, "-7:-0::o;x");
        send_stream(text);
        drain();

        // Saturated start, regular jump, clipped modifier, sixth field, open tail,
        // target never reached.
        write_target(32'hFFFF_FFFF);
        text.delete();
        put_text(text, "4294967296:::-:70000:1;2");
        send_stream(text);
        drain();

        // Receiver holds off while the sender keeps offering, then a full drain.
        write_target(32'd0);
        no_idle = 1'b1;
        holdoff_go = 1'b1;
        repeat (40)
        begin
            text.delete();
            put_text(text, $sformatf("%0d:%0d;", $urandom_range(0, 99), $urandom_range(0, 99)));
            send_stream(text);
        end
        drain();
        no_idle = 1'b0;

        while (item_count < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: target_now = 32'd0;
                1, 2, 3, 4, 5: target_now = $urandom_range(1, 5);
                6, 7: target_now = $urandom_range(6, 12);
                8: target_now = 32'hFFFF_FFFF;
                default: target_now = $urandom();
            endcase
            write_target(target_now);
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4))
            begin
                text.delete();
                if (target_now <= 12)
                    entries = ($urandom_range(0, 9) < 7) ? target_now + 1 + $urandom_range(0, 2)
                                                         : $urandom_range(0, target_now + 1);
                else
                    entries = $urandom_range(0, 8);
                repeat (entries)
                begin
                    case ($urandom_range(0, 19))
                        0, 1: ; // bare separator
                        2, 3: put_fields(text, $urandom_range(6, 7));
                        default: put_fields(text, $urandom_range(1, 5));
                    endcase
                    text.push_back(CHAR_SEMI);
                end
                if ($urandom_range(0, 9) < 3)
                    put_fields(text, $urandom_range(1, 3));
                send_stream(text);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
